>>> sv/ecpad_pkg.sv
// ----------------------------------------------------------------------------
// ecpad_pkg
// Shared types, constants and field arithmetic for the point unit.
// ----------------------------------------------------------------------------
package ecpad_pkg;

  localparam int unsigned FieldBits = 64;
  localparam int unsigned HalfBits  = FieldBits / 2;

  // pipeline timing shared by the unit and its checker
  localparam int unsigned MulLat  = 8;
  localparam int unsigned Steps   = 6;
  localparam int unsigned StepLat = MulLat + 1;
  localparam int unsigned Latency = Steps * StepLat + 1;

  typedef logic [FieldBits-1:0] fe_t;

  // register indexes of the configuration port
  localparam logic [1:0] RegModulus  = 2'd0;
  localparam logic [1:0] RegNegInv   = 2'd1;
  localparam logic [1:0] RegCurveA   = 2'd2;

  localparam fe_t ModulusReset = fe_t'(3);
  localparam fe_t NegInvReset  = 64'h5555_5555_5555_5555;
  localparam fe_t CurveAReset  = '0;

  typedef enum logic {
    OpAdd    = 1'b0,
    OpDouble = 1'b1
  } op_e;

  typedef struct packed {
    logic operation;
    fe_t  p_x;
    fe_t  p_y;
    fe_t  p_z;
    fe_t  q_x;
    fe_t  q_y;
  } in_item_t;

  typedef struct packed {
    fe_t r_x;
    fe_t r_y;
    fe_t r_z;
  } out_item_t;

  typedef struct packed {
    fe_t p;
    fe_t ninv;
    fe_t a;
  } cfg_t;

  // modular add, subtract p once
  function automatic fe_t f_add(fe_t x, fe_t y, fe_t p);
    logic [FieldBits:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s[FieldBits] || (s[FieldBits-1:0] >= p)) s = s - {1'b0, p};
    return s[FieldBits-1:0];
  endfunction

  // modular subtract, add p once on borrow
  function automatic fe_t f_sub(fe_t x, fe_t y, fe_t p);
    fe_t d;
    d = x - y;
    if (x < y) d = d + p;
    return d;
  endfunction

endpackage

>>> sv/ec_projective_point_add_double_unit.sv
// ----------------------------------------------------------------------------
// ec_projective_point_add_double_unit
// Projective mixed point addition and doubling, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: set modulus, mont_neg_inverse and curve_a_mont through the cfg
// write channel (cfg_valid_i/cfg_ready_o, index and data) while idle.
// An item is taken whenever start is high; busy is always low, so one
// item enters every cycle. The result leaves on result_o with done_o high
// for one cycle once the item has passed the whole chain below; items leave
// in order. The chain holds six multiply cells, each a bank of three
// 8-stage Montgomery multipliers, plus one register after each add/sub step
// and one entry register; its depth is Latency in the package. The
// receiver cannot stall; results are never held. Reset clears the valid
// chain and loads the register reset values; data in flight is dropped.
// ----------------------------------------------------------------------------
module ec_projective_point_add_double_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  ecpad_pkg::in_item_t   item_i,
  output logic                  done_o,
  output ecpad_pkg::out_item_t  result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  ecpad_pkg::fe_t        cfg_data_i
);
  import ecpad_pkg::*;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{p: ModulusReset, ninv: NegInvReset, a: CurveAReset};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegModulus: cfg_q.p    <= cfg_data_i;
        RegNegInv:  cfg_q.ninv <= cfg_data_i;
        RegCurveA:  cfg_q.a    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid chain
  logic [Latency-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[Latency-2:0], start};
  end
  assign done_o = vld_q[Latency-1];

  // live variables travel with the item: eight slots per step boundary
  localparam int unsigned NV = 8;
  typedef fe_t vars_t [NV];

  vars_t st_in  [Steps+1];   // values entering each step (registered)
  logic  op_d   [Steps+1];

  fe_t ma [Steps][3];
  fe_t mb [Steps][3];
  fe_t mr [Steps][3];

  // entry register
  always_ff @(posedge clk_i) begin
    st_in[0][0] <= item_i.p_x;
    st_in[0][1] <= item_i.p_y;
    st_in[0][2] <= item_i.p_z;
    st_in[0][3] <= item_i.q_x;
    st_in[0][4] <= item_i.q_y;
    st_in[0][5] <= '0;
    st_in[0][6] <= '0;
    st_in[0][7] <= '0;
    op_d[0]     <= item_i.operation;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    vars_t dly [MulLat+1];
    logic  od  [MulLat+1];
    assign dly[0] = st_in[s];
    assign od[0]  = op_d[s];
    // carry live values alongside the multipliers
    for (genvar k = 0; k < MulLat; k++) begin : g_dly
      always_ff @(posedge clk_i) begin
        dly[k+1] <= dly[k];
        od[k+1]  <= od[k];
      end
    end
    ecpad_alu_cell u_cell (
      .clk_i (clk_i),
      .cfg_i (cfg_q),
      .ma_i  (ma[s]),
      .mb_i  (mb[s]),
      .mr_o  (mr[s])
    );
    // operand select and post-processing for this step
    vars_t  v, o, n;
    logic   dbl;
    fe_t    p;
    assign v = st_in[s];
    assign o = dly[MulLat];
    assign p = cfg_q.p;
    assign dbl = (od[MulLat] == OpDouble);
    always_comb begin
      ma[s][0] = '0; mb[s][0] = '0;
      ma[s][1] = '0; mb[s][1] = '0;
      ma[s][2] = '0; mb[s][2] = '0;
      n = o;
      case (s)
        // add: qy*z, qx*z | dbl: x*x, z*z, y*z
        0: begin
          if (op_d[s] == OpDouble) begin
            ma[s][0] = v[0]; mb[s][0] = v[0];
            ma[s][1] = v[2]; mb[s][1] = v[2];
            ma[s][2] = v[1]; mb[s][2] = v[2];
          end else begin
            ma[s][0] = v[4]; mb[s][0] = v[2];
            ma[s][1] = v[3]; mb[s][1] = v[2];
          end
          if (dbl) begin
            // 5=xx 6=zz 3=s
            n[5] = mr[s][0];
            n[6] = mr[s][1];
            n[3] = f_add(mr[s][2], mr[s][2], p);
          end else begin
            // 3=u 4=v
            n[3] = f_sub(mr[s][0], o[1], p);
            n[4] = f_sub(mr[s][1], o[0], p);
          end
        end
        // add: u*u, v*v | dbl: a*zz, s*s, y*s
        1: begin
          if (op_d[s] == OpDouble) begin
            ma[s][0] = cfg_q.a; mb[s][0] = v[6];
            ma[s][1] = v[3];    mb[s][1] = v[3];
            ma[s][2] = v[1];    mb[s][2] = v[3];
          end else begin
            ma[s][0] = v[3]; mb[s][0] = v[3];
            ma[s][1] = v[4]; mb[s][1] = v[4];
          end
          if (dbl) begin
            // 4=w 6=ss 7=r
            n[4] = f_add(mr[s][0], f_add(f_add(o[5], o[5], p), o[5], p), p);
            n[6] = mr[s][1];
            n[7] = mr[s][2];
          end else begin
            // 5=uu 6=vv
            n[5] = mr[s][0];
            n[6] = mr[s][1];
          end
        end
        // add: v*vv, vv*x, uu*z | dbl: r*r, t3*t3, s*ss
        2: begin
          if (op_d[s] == OpDouble) begin
            ma[s][0] = v[7]; mb[s][0] = v[7];
            ma[s][1] = f_add(v[0], v[7], cfg_q.p); mb[s][1] = ma[s][1];
            ma[s][2] = v[3]; mb[s][2] = v[6];
          end else begin
            ma[s][0] = v[4]; mb[s][0] = v[6];
            ma[s][1] = v[6]; mb[s][1] = v[0];
            ma[s][2] = v[5]; mb[s][2] = v[2];
          end
          if (dbl) begin
            // 7=rr 1=b 2=z3
            n[7] = mr[s][0];
            n[1] = f_sub(f_sub(mr[s][1], o[5], p), mr[s][0], p);
            n[2] = mr[s][2];
          end else begin
            // 6=vvv 7=r 5=A
            n[6] = mr[s][0];
            n[7] = mr[s][1];
            n[5] = f_sub(f_sub(f_sub(mr[s][2], mr[s][0], p), mr[s][1], p),
                         mr[s][1], p);
          end
        end
        // add: v*A, vvv*y, vvv*z | dbl: w*w
        3: begin
          if (op_d[s] == OpDouble) begin
            ma[s][0] = v[4]; mb[s][0] = v[4];
          end else begin
            ma[s][0] = v[4]; mb[s][0] = v[5];
            ma[s][1] = v[6]; mb[s][1] = v[1];
            ma[s][2] = v[6]; mb[s][2] = v[2];
          end
          if (dbl) begin
            // 0=h
            n[0] = f_sub(f_sub(mr[s][0], o[1], p), o[1], p);
          end else begin
            // 0=x3 1=vvv*y 2=z3 5=r-A
            n[0] = mr[s][0];
            n[1] = mr[s][1];
            n[2] = mr[s][2];
            n[5] = f_sub(o[7], o[5], p);
          end
        end
        // add: u*(r-A) | dbl: w*(b-h), h*s
        4: begin
          if (op_d[s] == OpDouble) begin
            ma[s][0] = v[4]; mb[s][0] = f_sub(v[1], v[0], cfg_q.p);
            ma[s][1] = v[0]; mb[s][1] = v[3];
          end else begin
            ma[s][0] = v[3]; mb[s][0] = v[5];
          end
          if (dbl) begin
            n[1] = f_sub(f_sub(mr[s][0], o[7], p), o[7], p);
            n[0] = mr[s][1];
          end else begin
            n[1] = f_sub(mr[s][0], o[1], p);
          end
        end
        // final cell: pass through
        default: begin
          ma[s][0] = v[0]; mb[s][0] = v[0];
        end
      endcase
    end
    always_ff @(posedge clk_i) begin
      st_in[s+1] <= n;
      op_d[s+1]  <= od[MulLat];
    end
  end

  assign result_o.r_x = st_in[Steps][0];
  assign result_o.r_y = st_in[Steps][1];
  assign result_o.r_z = st_in[Steps][2];

endmodule

>>> sv/ecpad_mul_cell.sv
// ----------------------------------------------------------------------------
// ecpad_mul_cell
// Pipelined Montgomery multiplier, 32x32 partial products per stage.
// ----------------------------------------------------------------------------
module ecpad_mul_cell (
  input  logic                  clk_i,
  input  ecpad_pkg::fe_t        a_i,
  input  ecpad_pkg::fe_t        b_i,
  input  ecpad_pkg::cfg_t       cfg_i,
  output ecpad_pkg::fe_t        r_o
);
  import ecpad_pkg::*;

  localparam int unsigned W = FieldBits;
  localparam int unsigned H = HalfBits;

  // stage 1: partial products of a*b
  logic [W-1:0] ll_q, lh_q, hl_q, hh_q;
  always_ff @(posedge clk_i) begin
    ll_q <= {{H{1'b0}}, a_i[H-1:0]} * {{H{1'b0}}, b_i[H-1:0]};
    lh_q <= {{H{1'b0}}, a_i[H-1:0]} * {{H{1'b0}}, b_i[W-1:H]};
    hl_q <= {{H{1'b0}}, a_i[W-1:H]} * {{H{1'b0}}, b_i[H-1:0]};
    hh_q <= {{H{1'b0}}, a_i[W-1:H]} * {{H{1'b0}}, b_i[W-1:H]};
  end

  // stage 2: assemble t
  logic [2*W-1:0] t_q;
  always_ff @(posedge clk_i) begin
    t_q <= {hh_q, ll_q} + ({{H{1'b0}}, lh_q, {H{1'b0}}})
         + ({{H{1'b0}}, hl_q, {H{1'b0}}});
  end

  // stage 3: low partial products of m = tlo*ninv mod R
  logic [W-1:0]   m0_q, m1_q, m2_q;
  logic [2*W-1:0] t3_q;
  always_ff @(posedge clk_i) begin
    m0_q <= {{H{1'b0}}, t_q[H-1:0]} * {{H{1'b0}}, cfg_i.ninv[H-1:0]};
    m1_q <= {{H{1'b0}}, t_q[H-1:0]} * {{H{1'b0}}, cfg_i.ninv[W-1:H]};
    m2_q <= {{H{1'b0}}, t_q[W-1:H]} * {{H{1'b0}}, cfg_i.ninv[H-1:0]};
    t3_q <= t_q;
  end

  // stage 4: m
  logic [W-1:0]   m_q;
  logic [2*W-1:0] t4_q;
  always_ff @(posedge clk_i) begin
    m_q  <= m0_q + {m1_q[H-1:0], {H{1'b0}}} + {m2_q[H-1:0], {H{1'b0}}};
    t4_q <= t3_q;
  end

  // stage 5: partial products of m*p
  logic [W-1:0]   pl_q, plh_q, phl_q, ph_q;
  logic [2*W-1:0] t5_q;
  always_ff @(posedge clk_i) begin
    pl_q  <= {{H{1'b0}}, m_q[H-1:0]} * {{H{1'b0}}, cfg_i.p[H-1:0]};
    plh_q <= {{H{1'b0}}, m_q[H-1:0]} * {{H{1'b0}}, cfg_i.p[W-1:H]};
    phl_q <= {{H{1'b0}}, m_q[W-1:H]} * {{H{1'b0}}, cfg_i.p[H-1:0]};
    ph_q  <= {{H{1'b0}}, m_q[W-1:H]} * {{H{1'b0}}, cfg_i.p[W-1:H]};
    t5_q  <= t4_q;
  end

  // stage 6: m*p
  logic [2*W-1:0] mp_q, t6_q;
  always_ff @(posedge clk_i) begin
    mp_q <= {ph_q, pl_q} + ({{H{1'b0}}, plh_q, {H{1'b0}}})
          + ({{H{1'b0}}, phl_q, {H{1'b0}}});
    t6_q <= t5_q;
  end

  // stage 7: (t + m*p) / R
  logic [W:0] q_q;
  logic [2*W:0] sum;
  assign sum = {1'b0, t6_q} + {1'b0, mp_q};
  always_ff @(posedge clk_i) begin
    q_q <= sum[2*W:W];
  end

  // stage 8: final subtraction
  logic [W:0] qs;
  assign qs = q_q - {1'b0, cfg_i.p};
  always_ff @(posedge clk_i) begin
    r_o <= (q_q[W] || (q_q[W-1:0] >= cfg_i.p)) ? qs[W-1:0] : q_q[W-1:0];
  end

endmodule

>>> sv/ecpad_alu_cell.sv
// ----------------------------------------------------------------------------
// ecpad_alu_cell
// One cell of the chain: a bank of three multipliers; add/sub and delays sit in the step.
// ----------------------------------------------------------------------------
module ecpad_alu_cell (
  input  logic              clk_i,
  input  ecpad_pkg::cfg_t   cfg_i,
  input  ecpad_pkg::fe_t    ma_i [3],
  input  ecpad_pkg::fe_t    mb_i [3],
  output ecpad_pkg::fe_t    mr_o [3]
);
  import ecpad_pkg::*;

  // three multipliers per cell, one per product of the step
  for (genvar g = 0; g < 3; g++) begin : g_mul
    ecpad_mul_cell u_mul (
      .clk_i (clk_i),
      .a_i   (ma_i[g]),
      .b_i   (mb_i[g]),
      .cfg_i (cfg_i),
      .r_o   (mr_o[g])
    );
  end

endmodule

>>> sv/ecpad_checker.sv
// ----------------------------------------------------------------------------
// ecpad_checker
// Port-level checks of the point unit, bound to the top level.
// ----------------------------------------------------------------------------
module ecpad_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic cfg_ready_o
);
  import ecpad_pkg::*;

  // a done strobe only follows an item taken a fixed time before
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("done without item");

  // every item taken gives a strobe
  a_item_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency (done_o || !rst_ni))
    else $error("item lost");

  // the unit never blocks
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && cfg_ready_o)
    else $error("unit stalled");

endmodule

bind ec_projective_point_add_double_unit ecpad_checker u_ecpad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .cfg_ready_o (cfg_ready_o)
);

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the projective point add/double unit. A local
// Montgomery-arithmetic predictor computes each expected point unless a
// directed row gives a literal; results are compared field by field in order
// over several modulus settings, under bursty stimulus with random gaps.
// ----------------------------------------------------------------------------
module testbench;
  import ecpad_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 200;
  localparam int unsigned RandomItems   = 1850;
  localparam int unsigned NumPhases     = 4;

  typedef struct {
    in_item_t  item;
    bit        has_literal;
    out_item_t literal;
  } vector_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item_i = '0;
  logic      done_o;
  out_item_t result_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [1:0] cfg_index_i = RegModulus;
  fe_t       cfg_data_i = '0;

  // predictor copy of the registers
  fe_t model_p    = ModulusReset;
  fe_t model_ninv = NegInvReset;
  fe_t model_a    = CurveAReset;

  out_item_t pending_points[$];
  int unsigned mismatches = 0;
  int unsigned points_checked = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  bit          accepted_now;

  vector_t directed[$];

  ec_projective_point_add_double_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // montgomery product a*b/R, one conditional subtract of p
  function automatic fe_t mont_mul(fe_t x, fe_t y);
    logic [127:0] t;
    logic [127:0] mp;
    logic [128:0] sum;
    logic [64:0]  q;
    fe_t          m;
    t   = 128'(x) * 128'(y);
    m   = t[63:0] * model_ninv;
    mp  = 128'(m) * 128'(model_p);
    sum = {1'b0, t} + {1'b0, mp};
    q   = sum[128:64];
    if (q >= {1'b0, model_p}) q = q - {1'b0, model_p};
    return q[63:0];
  endfunction

  function automatic fe_t mod_add(fe_t x, fe_t y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, model_p}) s = s - {1'b0, model_p};
    return s[63:0];
  endfunction

  function automatic fe_t mod_sub(fe_t x, fe_t y);
    fe_t d;
    d = x - y;
    if (x < y) d = d + model_p;
    return d;
  endfunction

  // expected output point for one item
  function automatic out_item_t predict_point(in_item_t it);
    out_item_t res;
    fe_t u, uu, v, vv, vvv, r, a, xx, zz, w, s, ss, rr, b, h;
    if (op_e'(it.operation) == OpAdd) begin
      u   = mod_sub(mont_mul(it.q_y, it.p_z), it.p_y);
      uu  = mont_mul(u, u);
      v   = mod_sub(mont_mul(it.q_x, it.p_z), it.p_x);
      vv  = mont_mul(v, v);
      vvv = mont_mul(v, vv);
      r   = mont_mul(vv, it.p_x);
      a   = mod_sub(mod_sub(mod_sub(mont_mul(uu, it.p_z), vvv), r), r);
      res.r_x = mont_mul(v, a);
      res.r_y = mod_sub(mont_mul(u, mod_sub(r, a)), mont_mul(vvv, it.p_y));
      res.r_z = mont_mul(vvv, it.p_z);
    end else begin
      xx = mont_mul(it.p_x, it.p_x);
      zz = mont_mul(it.p_z, it.p_z);
      w  = mod_add(mont_mul(model_a, zz), mod_add(mod_add(xx, xx), xx));
      s  = mont_mul(it.p_y, it.p_z);
      s  = mod_add(s, s);
      ss = mont_mul(s, s);
      r  = mont_mul(it.p_y, s);
      rr = mont_mul(r, r);
      b  = mod_add(it.p_x, r);
      b  = mod_sub(mod_sub(mont_mul(b, b), xx), rr);
      h  = mod_sub(mod_sub(mont_mul(w, w), b), b);
      res.r_z = mont_mul(s, ss);
      res.r_x = mont_mul(h, s);
      res.r_y = mod_sub(mod_sub(mont_mul(w, mod_sub(b, h)), rr), rr);
    end
    return res;
  endfunction

  // -p^-1 mod 2^64 by newton iteration
  function automatic fe_t neg_inverse(fe_t p);
    fe_t inv;
    inv = p;
    for (int i = 0; i < 6; i++) inv = inv * (fe_t'(2) - p * inv);
    return -inv;
  endfunction

  function automatic fe_t rand_fe();
    return {$urandom, $urandom};
  endfunction

  // field value: mostly reduced, sometimes raw or an extreme
  function automatic fe_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return model_p - 1;
    if (pick == 2) return '1;
    if (pick < 6) return rand_fe();
    return rand_fe() % model_p;
  endfunction

  // result check against oldest expected point
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && done_o) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result_o);
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (result_o.r_x !== want.r_x || result_o.r_y !== want.r_y ||
            result_o.r_z !== want.r_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want x %h y %h z %h, got x %h y %h z %h",
                     want.r_x, want.r_y, want.r_z,
                     result_o.r_x, result_o.r_y, result_o.r_z);
        end
      end
    end
  end

  // watchdog on cycles with no item taken and no result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (accepted_now || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // valid stays high across back-to-back writes, the caller drops it
  task automatic write_reg(logic [1:0] idx, fe_t value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegModulus: model_p = value;
      RegNegInv:  model_ninv = value;
      RegCurveA:  model_a = value;
      default: ;
    endcase
  endtask

  // hold the item until taken, then record its expected point
  task automatic send_item(in_item_t it);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    accepted_now = 1'b1;
    pending_points.push_back(predict_point(it));
    items_sent++;
  endtask

  task automatic idle_gap(int unsigned n);
    start <= 1'b0;
    accepted_now = 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    idle_gap(1);
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic add_row(logic op, fe_t px, fe_t py, fe_t pz, fe_t qx, fe_t qy,
                         bit lit);
    vector_t row;
    row.item = '{operation: op, p_x: px, p_y: py, p_z: pz, q_x: qx, q_y: qy};
    row.has_literal = lit;
    row.literal = '0;
    directed.push_back(row);
  endtask

  initial begin
    in_item_t    it;
    fe_t         px, py, pz;
    int unsigned burst;
    fe_t         primes[NumPhases];
    primes[0] = 64'hFFFF_FFFF_FFFF_FFC5;
    primes[1] = 64'hFFFF_FFFF_0000_0001;
    primes[2] = 64'd65521;
    primes[3] = 64'hFFFF_FFFF_FFFF_FFC5;
    accepted_now = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows under reset registers
    px = rand_fe(); py = rand_fe(); pz = rand_fe();
    add_row(OpAdd,    '0, '0, '0, '0, '0, 1'b1);
    add_row(OpDouble, '0, '0, '0, '0, '0, 1'b1);
    add_row(OpAdd,    '1, '1, '1, '1, '1, 1'b0);
    add_row(OpDouble, '1, '1, '1, '1, '1, 1'b0);
    add_row(OpAdd,    64'd2, 64'd1, 64'd1, 64'd2, 64'd1, 1'b0);
    add_row(OpAdd,    64'd2, 64'd1, 64'd1, 64'd1, 64'd2, 1'b0);
    add_row(OpAdd,    px, py, '0, rand_fe(), rand_fe(), 1'b0);
    add_row(OpDouble, px, py, '0, '0, '0, 1'b0);
    // doubling must ignore q
    add_row(OpDouble, px, py, pz, '0, '0, 1'b0);
    add_row(OpDouble, px, py, pz, '1, '1, 1'b0);
    add_row(OpAdd,    px, py, pz, px, py, 1'b0);
    add_row(OpDouble, 64'd1, '0, 64'd1, '0, '0, 1'b0);
    add_row(OpAdd,    64'h8000_0000_0000_0000, 64'd1, 64'd2, '1, '0, 1'b0);
    foreach (directed[k]) begin
      send_item(directed[k].item);
      if (directed[k].has_literal) pending_points[$] = directed[k].literal;
    end
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_reg(RegModulus, primes[ph]);
      if (ph == 3) write_reg(RegNegInv, rand_fe());
      else write_reg(RegNegInv, neg_inverse(primes[ph]));
      case (ph)
        0: write_reg(RegCurveA, primes[ph] - 1);
        1: write_reg(RegCurveA, rand_fe() % primes[ph]);
        2: write_reg(RegCurveA, '0);
        default: write_reg(RegCurveA, '1);
      endcase
      cfg_valid_i <= 1'b0;
      while (items_sent < directed.size() + (ph + 1) * RandomItems / NumPhases) begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                            : $urandom_range(1, 16);
        repeat (burst) begin
          it.operation = 1'($urandom_range(0, 1));
          it.p_x = rand_coord();
          it.p_y = rand_coord();
          it.p_z = rand_coord();
          it.q_x = rand_coord();
          it.q_y = rand_coord();
          send_item(it);
        end
        if ($urandom_range(0, 60) == 0) begin
          idle_gap(1);
          while (pending_points.size() != 0) @(posedge clk_i);
        end else if ($urandom_range(0, 2) != 0) begin
          idle_gap($urandom_range(1, 12));
        end
      end
      drain();
    end

    $display("sent %0d items over %0d register settings, %0d points checked",
             items_sent, NumPhases + 1, points_checked);
    $display("mismatches %0d, left over %0d", mismatches, pending_points.size());
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
